FILE: sv/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants for the PID controller with anti-windup.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int FIELD_W   = 32;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int DT_FRAC   = 24;
  localparam int ALPHA_W   = 32;
  localparam int QUOT_W    = 57;
  localparam int REM_W     = 64;
  localparam int ITER_W    = 6;

  typedef enum logic [1:0] {
    OP_UPDATE    = 2'd0,
    OP_CLR_INTEG = 2'd1,
    OP_CLR_ALL   = 2'd2,
    OP_NONE      = 2'd3
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IBND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OBND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OMEGA = 3'd5;

  localparam logic [CFG_W-1:0] OBND_RESET = 31'd65536;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_BAD_DT = 1'b1;

  typedef enum logic [1:0] {
    SH_RAW   = 2'd0,
    SH_FRAC  = 2'd1,
    SH_DT    = 2'd2,
    SH_ALPHA = 2'd3
  } shift_sel_t;

  typedef struct packed {
    logic       start;
    logic       neg;
    shift_sel_t sel;
  } mul_ctl_t;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [FIELD_W-1:0] target;
    logic signed [FIELD_W-1:0] measurement;
    logic [FIELD_W-1:0]        time_step;
    logic                      integrate_enable;
  } in_t;

  typedef struct packed {
    logic                      status;
    logic signed [FIELD_W-1:0] drive_value;
  } out_t;

endpackage

FILE: sv/pidc_mul.sv
// ----------------------------------------------------------------------------
// pidc_mul
// Bit-serial sign-magnitude multiplier with floor shift and saturation.
// ----------------------------------------------------------------------------
module pidc_mul #(
  parameter int DW        = 32,
  parameter int FRAC_BITS = 16,
  parameter int MW        = (DW > 32) ? DW : 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pidc_pkg::mul_ctl_t   ctl,
  input  logic [MW-1:0]        a_mag,
  input  logic [MW-1:0]        b_mag,
  output logic                 done,
  output logic signed [DW-1:0] res,
  output logic [2*MW-1:0]      prod
);
  import pidc_pkg::*;

  localparam int PW   = 2 * MW;
  localparam int CNTW = $clog2(MW + 1);

  logic [MW:0]      hi_r, hi_nxt;
  logic [MW-1:0]    lo_r, lo_nxt;
  logic [MW-1:0]    a_r;
  logic [CNTW-1:0]  cnt_r;
  logic             run_r, done_r, neg_r;
  shift_sel_t       sel_r;
  logic [MW:0]      sum;

  assign sum    = hi_r + ((lo_r[0]) ? {1'b0, a_r} : '0);
  assign hi_nxt = {1'b0, sum[MW:1]};
  assign lo_nxt = {sum[0], lo_r[MW-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(MW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      hi_r  <= '0;
      lo_r  <= b_mag;
      a_r   <= a_mag;
      neg_r <= ctl.neg;
      sel_r <= ctl.sel;
    end else if (run_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign prod = {hi_r[MW-1:0], lo_r};
  assign done = done_r;

  logic [PW-1:0] q;
  logic          rem_nz;
  logic [DW:0]   lim, qt, mq, sv;
  logic          hi_nz;

  always_comb begin
    unique case (sel_r)
      SH_RAW: begin
        q      = prod;
        rem_nz = 1'b0;
      end
      SH_FRAC: begin
        q      = prod >> FRAC_BITS;
        rem_nz = |prod[FRAC_BITS-1:0];
      end
      SH_DT: begin
        q      = prod >> DT_FRAC;
        rem_nz = |prod[DT_FRAC-1:0];
      end
      SH_ALPHA: begin
        q      = prod >> ALPHA_W;
        rem_nz = |prod[ALPHA_W-1:0];
      end
      default: begin
        q      = prod;
        rem_nz = 1'b0;
      end
    endcase
    lim   = neg_r ? {2'b01, {(DW-1){1'b0}}} : {2'b00, {(DW-1){1'b1}}};
    hi_nz = |q[PW-1:DW];
    qt    = {1'b0, q[DW-1:0]} + (DW+1)'(neg_r & rem_nz);
    mq    = (hi_nz || (qt > lim)) ? lim : qt;
    sv    = neg_r ? (~mq + 1'b1) : mq;
    res   = sv[DW-1:0];
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !run_r) else $error("multiplier started while busy");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r)) else $error("multiplier done without a run");
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (cnt_r != '0)) else $error("multiplier count ran out");
`endif

endmodule

FILE: sv/pidc_div.sv
// ----------------------------------------------------------------------------
// pidc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pidc_pkg::REM_W-1:0]   rem_init,
  input  logic [pidc_pkg::REM_W-1:0]   divisor,
  input  logic [pidc_pkg::QUOT_W-1:0]  dividend,
  input  logic [pidc_pkg::ITER_W-1:0]  iters,
  output logic                         done,
  output logic [pidc_pkg::QUOT_W-1:0]  quot
);
  import pidc_pkg::*;

  logic [REM_W-1:0]  r_r, d_r, rs;
  logic [QUOT_W-1:0] n_r, q_r;
  logic [ITER_W-1:0] cnt_r;
  logic              run_r, done_r, ge;

  assign rs = {r_r[REM_W-2:0], n_r[QUOT_W-1]};
  assign ge = (rs >= d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= iters;
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ITER_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r_r <= rem_init;
      d_r <= divisor;
      n_r <= dividend;
      q_r <= '0;
    end else if (run_r) begin
      r_r <= ge ? (rs - d_r) : rs;
      n_r <= {n_r[QUOT_W-2:0], 1'b0};
      q_r <= {q_r[QUOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r) else $error("divider started while busy");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r)) else $error("divider done without a run");
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (cnt_r != '0)) else $error("divider count ran out");
`endif

endmodule

FILE: sv/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// PID step in signed fixed point with filtered derivative on the measurement
// and conditional-integration anti-windup.
// ----------------------------------------------------------------------------
// in_valid/in_ready take one item: opcode, set point, measurement, time step
// and integrate enable. out_valid/out_ready return one item per input item:
// status and clamped drive value. cfg_we/cfg_index/cfg_wdata write the gains,
// bounds and filter cutoff; write only while the block is idle.
// One item is worked on at a time. Clear opcodes, the unused opcode and a
// zero time step go straight to the result. An update runs a shared
// bit-serial multiplier and a shared bit-serial divider: up to 6 products
// and 2 divisions, the divisions for the rate and the filter gain; the first
// update after a full clear or after reset skips the derivative.
// A finished item moves to the output register; in_ready returns once it has
// moved there, so a stalled receiver holds one item in the output register
// and one finished item in the block.
// Reset restores the register defaults and clears the controller state.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pidc_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pidc_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidc_pkg::CFG_W-1:0]      cfg_wdata
);
  import pidc_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int MW = (DW > 32) ? DW : 32;
  localparam int CW = MW + 1;
  localparam logic signed [DW-1:0] MAX_D = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_D = {1'b1, {(DW-1){1'b0}}};
  localparam logic [REM_W-1:0] DEN_ONE = REM_W'(1) << (DT_FRAC + FRAC_BITS);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_P     = 12'b0000_0000_0010,
    S_RATE  = 12'b0000_0000_0100,
    S_D     = 12'b0000_0000_1000,
    S_NUM   = 12'b0000_0001_0000,
    S_ALPHA = 12'b0000_0010_0000,
    S_FD    = 12'b0000_0100_0000,
    S_KE    = 12'b0000_1000_0000,
    S_INC   = 12'b0001_0000_0000,
    S_CMT   = 12'b0010_0000_0000,
    S_OUT   = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  function automatic logic signed [DW-1:0] sat_cw(input logic signed [CW-1:0] x);
    if (x > CW'(MAX_D)) return MAX_D;
    if (x < CW'(MIN_D)) return MIN_D;
    return x[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    return sat_cw(CW'(a) + CW'(b));
  endfunction

  function automatic logic signed [DW-1:0] clamp_sym(input logic signed [DW-1:0] x,
                                                     input logic [CFG_W-1:0] b);
    logic signed [CW-1:0] xc, bc, nb;
    xc = CW'(x);
    bc = signed'(CW'(b));
    nb = -bc;
    if (xc > bc) return bc[DW-1:0];
    if (xc < nb) return nb[DW-1:0];
    return x;
  endfunction

  function automatic logic [MW-1:0] mag_d(input logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? DW'(-v) : DW'(v);
    return MW'(m);
  endfunction

  // configuration
  logic [CFG_W-1:0] kp_r, ki_r, kd_r, ibnd_r, obnd_r, omega_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      ibnd_r  <= '0;
      obnd_r  <= OBND_RESET;
      omega_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KP:    kp_r    <= cfg_wdata;
        CFG_KI:    ki_r    <= cfg_wdata;
        CFG_KD:    kd_r    <= cfg_wdata;
        CFG_IBND:  ibnd_r  <= cfg_wdata;
        CFG_OBND:  obnd_r  <= cfg_wdata;
        CFG_OMEGA: omega_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // controller state and working registers
  state_t                    state_r, state_nxt;
  logic                      launched_r, launched_nxt;
  logic signed [DW-1:0]      integ_r, integ_nxt;
  logic signed [DW-1:0]      fd_r, fd_nxt;
  logic signed [FIELD_W-1:0] last_r, last_nxt;
  logic                      have_prev_r, have_prev_nxt;
  logic signed [DW-1:0]      e_r, e_nxt, p_r, p_nxt, rate_r, rate_nxt;
  logic signed [DW-1:0]      d_r, d_nxt, ke_r, ke_nxt, inc_r, inc_nxt;
  logic signed [FIELD_W-1:0] meas_r, meas_nxt;
  logic [FIELD_W-1:0]        dt_r, dt_nxt;
  logic                      ie_r, ie_nxt;
  logic [ALPHA_W-1:0]        alpha_r, alpha_nxt;
  logic [REM_W-1:0]          num_r, num_nxt, den_r, den_nxt;
  logic                      res_status_r, res_status_nxt;
  logic signed [DW-1:0]      res_drive_r, res_drive_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_t                      out_data_r, out_data_nxt;

  // shared arithmetic units
  mul_ctl_t              mul_ctl;
  logic [MW-1:0]         mul_a, mul_b;
  logic                  mul_done;
  logic signed [DW-1:0]  mul_res;
  logic [2*MW-1:0]       mul_prod;
  logic                  div_start, div_done;
  logic [REM_W-1:0]      div_rem_init, div_divisor;
  logic [QUOT_W-1:0]     div_dividend, div_quot;
  logic [ITER_W-1:0]     div_iters;

  pidc_mul #(
    .DW        (DW),
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a_mag (mul_a),
    .b_mag (mul_b),
    .done  (mul_done),
    .res   (mul_res),
    .prod  (mul_prod)
  );

  pidc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem_init),
    .divisor  (div_divisor),
    .dividend (div_dividend),
    .iters    (div_iters),
    .done     (div_done),
    .quot     (div_quot)
  );

  // derived values
  logic signed [32:0]    diff;
  logic [32:0]           diff_mag;
  logic                  diff_neg;
  logic [DW:0]           rate_lim;
  logic [QUOT_W-1:0]     rate_lim_q, rate_mq;
  logic [DW:0]           rate_sv;
  logic signed [DW-1:0]  fd_x;
  logic [REM_W-1:0]      nf, df;
  logic signed [DW-1:0]  cand, co, rsum;
  logic signed [CW-1:0]  co_c, ob_c;
  logic                  e_neg, e_pos, commit;
  logic signed [MW-1:0]  drive_ext;

  always_comb begin
    diff       = {meas_r[FIELD_W-1], meas_r} - {last_r[FIELD_W-1], last_r};
    diff_neg   = diff[32];
    diff_mag   = diff_neg ? 33'(-diff) : 33'(diff);
    rate_lim   = diff_neg ? {2'b01, {(DW-1){1'b0}}} : {2'b00, {(DW-1){1'b1}}};
    rate_lim_q = QUOT_W'(rate_lim);
    rate_mq    = (div_quot > rate_lim_q) ? rate_lim_q : div_quot;
    rate_sv    = diff_neg ? (~rate_mq[DW:0] + 1'b1) : rate_mq[DW:0];
    fd_x       = sat_cw(CW'(d_r) - CW'(fd_r));
    nf         = mul_prod[REM_W-1:0];
    df         = DEN_ONE + nf;
    if (df[REM_W-1]) begin
      nf = nf >> 2;
      df = df >> 2;
    end else if (df[REM_W-2]) begin
      nf = nf >> 1;
      df = df >> 1;
    end
    e_neg     = e_r[DW-1];
    e_pos     = !e_r[DW-1] && (e_r != '0);
    cand      = clamp_sym(sat_add(integ_r, inc_r), ibnd_r);
    co        = sat_add(sat_add(p_r, cand), fd_r);
    co_c      = CW'(co);
    ob_c      = signed'(CW'(obnd_r));
    commit    = ((co_c <= ob_c) || e_neg) && ((co_c >= -ob_c) || e_pos);
    rsum      = clamp_sym(sat_add(sat_add(p_r, integ_r), fd_r), obnd_r);
    drive_ext = MW'(res_drive_r);
  end

  // multiplier and divider operands
  always_comb begin
    mul_ctl.start = 1'b0;
    mul_ctl.neg   = 1'b0;
    mul_ctl.sel   = SH_FRAC;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_rem_init  = '0;
    div_divisor   = REM_W'(dt_r);
    div_dividend  = '0;
    div_iters     = ITER_W'(QUOT_W);
    unique case (state_r)
      S_P: begin
        mul_ctl.start = !launched_r;
        mul_ctl.neg   = e_neg;
        mul_a         = MW'(kp_r);
        mul_b         = mag_d(e_r);
      end
      S_RATE: begin
        div_start    = !launched_r;
        div_dividend = {diff_mag, {DT_FRAC{1'b0}}};
      end
      S_D: begin
        mul_ctl.start = !launched_r;
        mul_ctl.neg   = !rate_r[DW-1] && (rate_r != '0);
        mul_a         = MW'(kd_r);
        mul_b         = mag_d(rate_r);
      end
      S_NUM: begin
        mul_ctl.start = !launched_r;
        mul_ctl.sel   = SH_RAW;
        mul_a         = MW'(dt_r);
        mul_b         = MW'(omega_r);
      end
      S_ALPHA: begin
        div_start    = !launched_r;
        div_rem_init = num_r;
        div_divisor  = den_r;
        div_iters    = ITER_W'(ALPHA_W);
      end
      S_FD: begin
        mul_ctl.start = !launched_r;
        mul_ctl.neg   = fd_x[DW-1];
        mul_ctl.sel   = SH_ALPHA;
        mul_a         = mag_d(fd_x);
        mul_b         = MW'(alpha_r);
      end
      S_KE: begin
        mul_ctl.start = !launched_r;
        mul_ctl.neg   = e_neg;
        mul_a         = MW'(ki_r);
        mul_b         = mag_d(e_r);
      end
      S_INC: begin
        mul_ctl.start = !launched_r;
        mul_ctl.neg   = ke_r[DW-1];
        mul_ctl.sel   = SH_DT;
        mul_a         = mag_d(ke_r);
        mul_b         = MW'(dt_r);
      end
      default: ;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    launched_nxt   = launched_r;
    integ_nxt      = integ_r;
    fd_nxt         = fd_r;
    last_nxt       = last_r;
    have_prev_nxt  = have_prev_r;
    e_nxt          = e_r;
    p_nxt          = p_r;
    rate_nxt       = rate_r;
    d_nxt          = d_r;
    ke_nxt         = ke_r;
    inc_nxt        = inc_r;
    meas_nxt       = meas_r;
    dt_nxt         = dt_r;
    ie_nxt         = ie_r;
    alpha_nxt      = alpha_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    res_status_nxt = res_status_r;
    res_drive_nxt  = res_drive_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    if (mul_ctl.start || div_start) launched_nxt = 1'b1;
    if (mul_done || div_done) launched_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt = STATUS_OK;
          res_drive_nxt  = '0;
          state_nxt      = S_DONE;
          unique case (in_data.opcode)
            OP_CLR_INTEG: integ_nxt = '0;
            OP_CLR_ALL: begin
              integ_nxt     = '0;
              fd_nxt        = '0;
              last_nxt      = '0;
              have_prev_nxt = 1'b0;
            end
            OP_UPDATE: begin
              if (in_data.time_step == '0) begin
                res_status_nxt = STATUS_BAD_DT;
              end else begin
                e_nxt     = sat_cw(CW'(in_data.target) - CW'(in_data.measurement));
                meas_nxt  = in_data.measurement;
                dt_nxt    = in_data.time_step;
                ie_nxt    = in_data.integrate_enable;
                state_nxt = S_P;
              end
            end
            default: ;
          endcase
        end
      end
      S_P: begin
        if (mul_done) begin
          p_nxt = mul_res;
          if (have_prev_r) begin
            state_nxt = S_RATE;
          end else begin
            fd_nxt    = '0;
            state_nxt = ie_r ? S_KE : S_OUT;
          end
        end
      end
      S_RATE: begin
        if (div_done) begin
          rate_nxt  = rate_sv[DW-1:0];
          state_nxt = S_D;
        end
      end
      S_D: begin
        if (mul_done) begin
          d_nxt = mul_res;
          if (omega_r == '0) begin
            fd_nxt    = mul_res;
            state_nxt = ie_r ? S_KE : S_OUT;
          end else begin
            state_nxt = S_NUM;
          end
        end
      end
      S_NUM: begin
        if (mul_done) begin
          num_nxt   = nf;
          den_nxt   = df;
          state_nxt = S_ALPHA;
        end
      end
      S_ALPHA: begin
        if (div_done) begin
          alpha_nxt = div_quot[ALPHA_W-1:0];
          state_nxt = S_FD;
        end
      end
      S_FD: begin
        if (mul_done) begin
          fd_nxt    = sat_add(fd_r, mul_res);
          state_nxt = ie_r ? S_KE : S_OUT;
        end
      end
      S_KE: begin
        if (mul_done) begin
          ke_nxt    = mul_res;
          state_nxt = S_INC;
        end
      end
      S_INC: begin
        if (mul_done) begin
          inc_nxt   = mul_res;
          state_nxt = S_CMT;
        end
      end
      S_CMT: begin
        if (commit) integ_nxt = cand;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res_status_nxt = STATUS_OK;
        res_drive_nxt  = rsum;
        last_nxt       = meas_r;
        have_prev_nxt  = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.drive_value = drive_ext[FIELD_W-1:0];
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      fd_r        <= '0;
      last_r      <= '0;
      have_prev_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      fd_r        <= fd_nxt;
      last_r      <= last_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r          <= e_nxt;
    p_r          <= p_nxt;
    rate_r       <= rate_nxt;
    d_r          <= d_nxt;
    ke_r         <= ke_nxt;
    inc_r        <= inc_nxt;
    meas_r       <= meas_nxt;
    dt_r         <= dt_nxt;
    ie_r         <= ie_nxt;
    alpha_r      <= alpha_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    res_status_r <= res_status_nxt;
    res_drive_r  <= res_drive_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_P || state_r == S_D || state_r == S_NUM ||
                  state_r == S_FD || state_r == S_KE || state_r == S_INC))
    else $error("multiplier result with no consumer");
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_RATE || state_r == S_ALPHA))
    else $error("divider result with no consumer");
  a_update_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.opcode == OP_UPDATE && in_data.time_step != '0)
    |=> (state_r == S_P)) else $error("update item did not start");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the hand-over state");
`endif

endmodule
